### hw/rtl/mic_pkg.sv
// Shared types and constants of the multiprocessor interrupt controller.
// No dependencies; the core and the top level import this package.
package mic_pkg;

   localparam int unsigned NumCpus = 16;
   localparam int unsigned Slots = 16;
   localparam logic [4:0] CpuLimit = 5'(NumCpus);

   // Transaction kinds.
   localparam logic [1:0] KindRead = 2'd0;
   localparam logic [1:0] KindWrite = 2'd1;
   localparam logic [1:0] KindLine = 2'd2;
   localparam logic [1:0] KindAck = 2'd3;

   // Fixed register offsets in the low region.
   localparam logic [7:0] AddrLevel = 8'h00;
   localparam logic [7:0] AddrPending = 8'h04;
   localparam logic [7:0] AddrForce0 = 8'h08;
   localparam logic [7:0] AddrClear = 8'h0C;
   localparam logic [7:0] AddrBroadcast = 8'h14;

   // Address regions selected by offset bits 7:6.
   localparam logic [1:0] RegionLow = 2'd0;
   localparam logic [1:0] RegionMask = 2'd1;
   localparam logic [1:0] RegionForce = 2'd2;
   localparam logic [1:0] RegionExt = 2'd3;

   localparam logic [15:0] LowClean = 16'hFFFE;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] address;
      logic [31:0] write_data;
      logic [3:0] irq_num;
      logic line_high;
   } item_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [15:0] irq_request;
      logic irq_update;
   } result_type;

endpackage

### hw/rtl/mic_core.sv
// Register file and request evaluation of the interrupt controller.
// Depends on mic_pkg for the item and result structs and the register map.
module mic_core (
   input logic clock,
   input logic reset,
   input logic exec,
   input mic_pkg::item_type item,
   output mic_pkg::result_type result
);
   import mic_pkg::*;

   logic [15:0] level_ff, level_in;
   logic [15:0] pending_ff, pending_in;
   logic [15:0] bcast_ff, bcast_in;
   logic [31:0] mask_ff [Slots];
   logic [31:0] mask_in [Slots];
   logic [15:0] force_ff [Slots];
   logic [15:0] force_in [Slots];
   logic [3:0] ext_ff [Slots];
   logic [3:0] ext_in [Slots];

   logic [3:0] slot;
   logic slot_ok;
   logic [15:0] line_bit;
   logic [15:0] set_bits;
   logic [15:0] clr_bits;
   logic [15:0] req_all;
   logic [15:0] req_high;
   logic [31:0] rd_data;
   logic upd;

   assign slot = item.address[5:2];
   assign slot_ok = {1'b0, slot} < CpuLimit;
   assign line_bit = 16'd1 << item.irq_num;
   assign set_bits = item.write_data[15:0] & LowClean;
   assign clr_bits = item.write_data[31:16] & LowClean;

   // Bus read mux on the current register contents.
   always_comb begin
      rd_data = 32'd0;
      if (item.kind == KindRead) begin
         if (item.address[7:6] == RegionLow) begin
            unique case (item.address)
               AddrLevel: rd_data = {16'd0, level_ff};
               AddrPending: rd_data = {16'd0, pending_ff};
               AddrForce0: rd_data = {16'd0, force_ff[0]};
               AddrBroadcast: rd_data = {16'd0, bcast_ff};
               default: rd_data = 32'd0;
            endcase
         end else if (slot_ok) begin
            unique case (item.address[7:6])
               RegionMask: rd_data = mask_ff[slot];
               RegionForce: rd_data = {16'd0, force_ff[slot]};
               RegionExt: rd_data = {28'd0, ext_ff[slot]};
               default: rd_data = 32'd0;
            endcase
         end
      end
   end

   // Next-state logic for writes, line events and acknowledges.
   always_comb begin
      level_in = level_ff;
      pending_in = pending_ff;
      bcast_in = bcast_ff;
      mask_in = mask_ff;
      force_in = force_ff;
      ext_in = ext_ff;
      upd = 1'b0;
      unique case (item.kind)
         KindRead: upd = 1'b0;
         KindWrite: begin
            if (item.address[7:6] == RegionLow) begin
               unique case (item.address)
                  AddrLevel: level_in = item.write_data[15:0] & LowClean;
                  AddrForce0: begin
                     force_in[0] = set_bits;
                     upd = 1'b1;
                  end
                  AddrClear: pending_in = pending_ff & ~set_bits;
                  AddrBroadcast: bcast_in = item.write_data[15:0] & LowClean;
                  default: upd = 1'b0;
               endcase
            end else if (slot_ok) begin
               unique case (item.address[7:6])
                  RegionMask: begin
                     mask_in[slot] = {item.write_data[31:1], 1'b0};
                     upd = 1'b1;
                  end
                  RegionForce: begin
                     force_in[slot] = (force_ff[slot] | set_bits) & ~clr_bits;
                     upd = 1'b1;
                  end
                  RegionExt: ext_in[slot] = item.write_data[3:0];
                  default: upd = 1'b0;
               endcase
            end
         end
         KindLine: begin
            if (item.line_high) begin
               // A broadcast line goes to the force register of every processor.
               if ((bcast_ff & line_bit) != 16'd0) begin
                  for (int i = 0; i < Slots; i++) begin
                     if (i < NumCpus) begin
                        force_in[i] = force_ff[i] | line_bit;
                     end
                  end
               end else begin
                  pending_in = pending_ff | line_bit;
               end
               upd = 1'b1;
            end
         end
         KindAck: begin
            pending_in = pending_ff & ~line_bit;
            force_in[0] = force_ff[0] & ~line_bit;
            upd = 1'b1;
         end
         default: upd = 1'b0;
      endcase
   end

   // The request reflects the state after this transaction.
   assign req_all = (pending_in | force_in[0]) & mask_in[0][15:0];
   assign req_high = req_all & level_in;

   always_comb begin
      result.read_data = rd_data;
      result.irq_update = upd;
      result.irq_request = 16'd0;
      if (upd) begin
         result.irq_request = (req_high != 16'd0) ? req_high : (req_all & ~level_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 16'd0;
         pending_ff <= 16'd0;
         bcast_ff <= 16'd0;
         for (int i = 0; i < Slots; i++) begin
            mask_ff[i] <= 32'd0;
            force_ff[i] <= 16'd0;
            ext_ff[i] <= 4'd0;
         end
      end else if (exec) begin
         level_ff <= level_in;
         pending_ff <= pending_in;
         bcast_ff <= bcast_in;
         mask_ff <= mask_in;
         force_ff <= force_in;
         ext_ff <= ext_in;
      end
   end

endmodule

### hw/rtl/multiprocessor_interrupt_controller_top.sv
// A sixteen-line, two-level interrupt controller behind a 256-byte register map.
// Each transaction (bus read, bus write, line event or acknowledge) is captured
// in an input register, applied to the register file once the result register
// is free or draining, and answered from a result register. One transaction is
// taken every cycle while the result side keeps up; the rate is set by the
// read-modify-write of the register file. Every transaction returns exactly one
// result.
// Depends on mic_pkg and mic_core.
module multiprocessor_interrupt_controller_top (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [1:0] req_kind,
   input logic [7:0] req_address,
   input logic [31:0] req_write_data,
   input logic [3:0] req_irq_num,
   input logic req_line_high,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic [15:0] rsp_irq_request,
   output logic rsp_irq_update
);
   import mic_pkg::*;

   item_type item_ff;
   logic item_valid_ff;
   result_type res_ff;
   logic rsp_valid_ff;
   result_type core_res;
   logic advance;
   logic accept;

   // The held transaction moves on when the result register is free or draining.
   assign advance = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign accept = req_valid && req_ready;

   mic_core u_core (
      .clock(clock),
      .reset(reset),
      .exec(advance),
      .item(item_ff),
      .result(core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            item_valid_ff <= 1'b1;
         end else if (advance) begin
            item_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.kind <= req_kind;
         item_ff.address <= req_address;
         item_ff.write_data <= req_write_data;
         item_ff.irq_num <= req_irq_num;
         item_ff.line_high <= req_line_high;
      end
      if (advance) begin
         res_ff <= core_res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_data = res_ff.read_data;
   assign rsp_irq_request = res_ff.irq_request;
   assign rsp_irq_update = res_ff.irq_update;

endmodule
